### src/voxel_redundancy_test_26_top_macros.svh
// Assertion macros used by the voxel redundancy test checker.
`ifndef VOXEL_REDUNDANCY_TEST_26_TOP_MACROS_SVH
`define VOXEL_REDUNDANCY_TEST_26_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define VRT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("voxel redundancy check failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off during reset.
`define VRT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("voxel redundancy check failed: next-cycle implication");

`endif

### src/vrt_pkg.sv
// Types and constants shared by the voxel redundancy test block.
package vrt_pkg;

  // One 3x3 slice mask, bit row*3+col
  localparam int SLICE_W = 9;

  typedef logic [SLICE_W-1:0] slice_t;

endpackage

### src/vrt_if.sv
// Valid/ready channel interfaces for neighborhood words and result words.
interface vrt_in_if import vrt_pkg::*; ();
  logic   valid;
  logic   ready;
  slice_t prev_slice;
  slice_t cur_slice;
  slice_t next_slice;

  modport source (output valid, output prev_slice, output cur_slice,
                  output next_slice, input ready);
  modport sink (input valid, input prev_slice, input cur_slice,
                input next_slice, output ready);
endinterface

interface vrt_out_if ();
  logic valid;
  logic ready;
  logic removable;

  modport source (output valid, output removable, input ready);
  modport sink (input valid, input removable, output ready);
endinterface

### src/voxel_redundancy_test_26_top.sv
// Top level of the 3x3x3 voxel redundancy test.
// Takes one neighborhood word per clock while the output is not stalled and
// returns one removable word for each. A word is held in an input register,
// evaluated by a single pass of bit logic and caught in the result register,
// which drives the output; the input register takes a new word whenever it is
// empty or its word moves on, so the input keeps accepting while a result
// waits, until both registers are full.
module voxel_redundancy_test_26_top import vrt_pkg::*; (
  input logic      clk,
  input logic      rst,
  vrt_in_if.sink   vox_in,
  vrt_out_if.source res_out
);

  logic   s1_valid;
  slice_t s1_prev, s1_cur, s1_next;
  logic   s2_valid;
  logic   s2_removable;
  logic   s1_adv, s2_adv;
  logic   eval_removable;

  // Advance each stage when it is empty or its word moves on
  assign s2_adv       = !s2_valid || res_out.ready;
  assign s1_adv       = !s1_valid || s2_adv;
  assign vox_in.ready = s1_adv;

  vrt_eval u_eval (
    .prev_slice (s1_prev),
    .cur_slice  (s1_cur),
    .next_slice (s1_next),
    .removable  (eval_removable)
  );

  // Stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_adv) s1_valid <= vox_in.valid;
      if (s2_adv) s2_valid <= s1_valid;
    end
  end

  // Capture input word and result word
  always_ff @(posedge clk) begin
    if (s1_adv && vox_in.valid) begin
      s1_prev <= vox_in.prev_slice;
      s1_cur  <= vox_in.cur_slice;
      s1_next <= vox_in.next_slice;
    end
    if (s2_adv && s1_valid) s2_removable <= eval_removable;
  end

  assign res_out.valid     = s2_valid;
  assign res_out.removable = s2_removable;

endmodule

### src/vrt_eval.sv
// Combinational 26-neighborhood removability test of the center voxel.
module vrt_eval import vrt_pkg::*; (
  input  slice_t prev_slice,
  input  slice_t cur_slice,
  input  slice_t next_slice,
  output logic   removable
);

  // Count set bits among the eight non-center positions
  function automatic logic [3:0] nbr_count(input slice_t m);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < SLICE_W; i++) begin
      if (i != 4) n = n + 4'(m[i]);
    end
    return n;
  endfunction

  // 2D 8-neighborhood redundancy test
  function automatic logic redundant8(input slice_t m);
    if (!m[4]) return 1'b0;
    if (nbr_count(m) <= 4'd1) return 1'b0;
    if (m[0] && !m[3] && !m[1]) return 1'b0;
    if (m[6] && !m[3] && !m[7]) return 1'b0;
    if (m[2] && !m[5] && !m[1]) return 1'b0;
    if (m[8] && !m[5] && !m[7]) return 1'b0;
    if (!m[3] && !m[5] && m[1] && m[7]) return 1'b0;
    if (!m[1] && !m[7] && m[3] && m[5]) return 1'b0;
    return 1'b1;
  endfunction

  // Outer slice fully connected through the union with the current slice
  function automatic logic complete_conn(input slice_t cu, input slice_t s);
    if (s[4]) return 1'b1;
    return redundant8(cu | s);
  endfunction

  // Outer slice partially connected: corner and edge rules
  function automatic logic partial_conn(input slice_t cu, input slice_t s);
    logic [3:0] ncur;
    logic       one;
    logic       e1, e2, e3, e4;
    ncur = nbr_count(cu);
    one  = (ncur == 4'd1);
    e1   = s[3];
    e2   = s[1];
    e3   = s[5];
    e4   = s[7];
    if (nbr_count(s) == 4'd0) return 1'b1;
    if (ncur == 4'd0) return 1'b0;
    if (s[4]) return 1'b1;
    // corners with no path into the current slice
    if (s[0] && !cu[0] && !cu[1] && !cu[3] && !s[1] && !s[3]) return 1'b0;
    if (s[2] && !cu[2] && !cu[1] && !cu[5] && !s[1] && !s[5]) return 1'b0;
    if (s[6] && !cu[6] && !cu[7] && !cu[3] && !s[7] && !s[3]) return 1'b0;
    if (s[8] && !cu[8] && !cu[7] && !cu[5] && !s[7] && !s[5]) return 1'b0;
    // adjacent edge pairs facing a lone opposite corner
    if (e1 && e2 && !e3 && !e4 && cu[8] && one) return 1'b0;
    if (!e1 && e2 && e3 && !e4 && cu[6] && one) return 1'b0;
    if (!e1 && !e2 && e3 && e4 && cu[0] && one) return 1'b0;
    if (e1 && !e2 && !e3 && e4 && cu[2] && one) return 1'b0;
    // opposite edge pairs across an empty side
    if (!e1 && e2 && !e3 && e4 && !cu[3] && !cu[5] &&
        ((!cu[0] && !cu[1] && !cu[2]) || (!cu[6] && !cu[7] && !cu[8]))) return 1'b0;
    if (e1 && !e2 && e3 && !e4 && !cu[1] && !cu[7] &&
        ((!cu[0] && !cu[3] && !cu[6]) || (!cu[2] && !cu[5] && !cu[8]))) return 1'b0;
    // single edge with its side of the current slice empty
    if (e1 && !e2 && !e3 && !e4 &&
        !cu[0] && !cu[1] && !cu[3] && !cu[6] && !cu[7]) return 1'b0;
    if (!e1 && e2 && !e3 && !e4 &&
        !cu[0] && !cu[1] && !cu[2] && !cu[3] && !cu[5]) return 1'b0;
    if (!e1 && !e2 && e3 && !e4 &&
        !cu[1] && !cu[2] && !cu[5] && !cu[7] && !cu[8]) return 1'b0;
    if (!e1 && !e2 && !e3 && e4 &&
        !cu[3] && !cu[5] && !cu[6] && !cu[7] && !cu[8]) return 1'b0;
    return 1'b1;
  endfunction

  logic [3:0] np, nc, nn;
  logic [4:0] ntotal;

  // Gate on center, neighbor totals, then the slice connection tests
  always_comb begin
    np     = nbr_count(prev_slice);
    nc     = nbr_count(cur_slice);
    nn     = nbr_count(next_slice);
    ntotal = 5'(np) + 5'(nc) + 5'(nn);
    if (!cur_slice[4] || ntotal < 5'd2 || nc == 4'd0) begin
      removable = 1'b0;
    end else begin
      removable = (complete_conn(cur_slice, prev_slice) &&
                   partial_conn(cur_slice, next_slice)) ||
                  (complete_conn(cur_slice, next_slice) &&
                   partial_conn(cur_slice, prev_slice));
    end
  end

endmodule

### src/vrt_checker.sv
// Port-level checks of the voxel redundancy test top level.
`include "voxel_redundancy_test_26_top_macros.svh"

module vrt_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic removable
);

  // No result word right out of reset
  `VRT_ASSERT_IMP(a_no_out_after_rst, $past(rst), !out_valid)
  // An empty output side never blocks the input
  `VRT_ASSERT_IMP(a_ready_when_out_idle, !out_valid, in_ready)
  // A fresh result traces back to a word accepted through the input register
  `VRT_ASSERT_IMP(a_out_has_source, $rose(out_valid), $past(in_valid && in_ready, 2))
  // Hold a stalled result word
  `VRT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(removable))

endmodule

bind voxel_redundancy_test_26_top vrt_checker u_vrt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (vox_in.valid),
  .in_ready  (vox_in.ready),
  .out_valid (res_out.valid),
  .out_ready (res_out.ready),
  .removable (res_out.removable)
);
